/* rtl/assert_macros.svh */
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every edge outside reset
`define PIDL_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("pidl assertion failed");

// implication whose consequent is checked in the cycle after the trigger
`define PIDL_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("pidl assertion failed");

`endif

/* rtl/pidl_pkg.sv */
// types and constants for the positional insert/delete list
package pidl_pkg;

  localparam int unsigned CMD_W    = 3;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned POS_W    = 6;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned CNT_W    = 6;

  typedef enum logic [CMD_W-1:0] {
    CMD_INS_FIRST = 3'd0,
    CMD_INS_LAST  = 3'd1,
    CMD_INS_AT    = 3'd2,
    CMD_DEL_FIRST = 3'd3,
    CMD_DEL_LAST  = 3'd4,
    CMD_DEL_AT    = 3'd5,
    CMD_DUMP      = 3'd6
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_FULL   = 2'd3
  } status_e;

endpackage

/* rtl/pidl_if.sv */
// command and result channel interfaces
interface pidl_cmd_if import pidl_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [CMD_W-1:0]          command;
  logic signed [VALUE_W-1:0] value;
  logic [POS_W-1:0]          position;

  modport source (output valid, command, value, position, input ready);
  modport sink (input valid, command, value, position, output ready);
endinterface

interface pidl_res_if import pidl_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] entry_value;
  logic [STATUS_W-1:0]       status;
  logic [CNT_W-1:0]          entry_count;
  logic                      last;

  modport source (output valid, entry_value, status, entry_count, last, input ready);
  modport sink (input valid, entry_value, status, entry_count, last, output ready);
endinterface

/* rtl/positional_insert_delete_list_top.sv */
// bounded ordered list with positional insert, delete and dump, entries held in one memory
// insert at index i: entries from i to the tail move up one place, last first, then the value is written at i
// delete at index i: later entries move down one place, none for the tail (one entry moved per cycle)
// dump: each entry is read from memory, then loaded into the result register; errors skip the memory
// a command beat is taken only when the sequencer is idle; the result register decouples the sink
// reset clears the count, sequencer and result register; memory contents stay undefined
module positional_insert_delete_list_top import pidl_pkg::*; #(
  parameter int unsigned CAPACITY = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  pidl_cmd_if.sink   cmd_i,
  pidl_res_if.source res_o
);

  localparam int unsigned AW   = $clog2(CAPACITY);
  localparam int unsigned CW   = $clog2(CAPACITY + 1);
  localparam int unsigned CMPW = ((CW > POS_W) ? CW : POS_W) + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT,
    S_RESP,
    S_DUMP_RD,
    S_DUMP_WR
  } state_e;

  state_e                    state_q;
  logic [CW-1:0]             cnt_q;
  logic [AW-1:0]             idx_q;
  logic [AW-1:0]             ptr_q;
  logic [AW-1:0]             dst_q;
  logic [CW-1:0]             rem_q;
  logic                      mv_q;
  logic                      up_q;
  logic signed [VALUE_W-1:0] val_q;
  status_e                   st_q;

  logic                      res_valid_q;
  logic signed [VALUE_W-1:0] res_value_q;
  status_e                   res_status_q;
  logic [CNT_W-1:0]          res_count_q;
  logic                      res_last_q;

  logic signed [VALUE_W-1:0] entries_q [CAPACITY];
  logic signed [VALUE_W-1:0] rd_data_q;

  logic                      mem_we;
  logic [AW-1:0]             mem_waddr;
  logic signed [VALUE_W-1:0] mem_wdata;
  logic                      mem_re;
  logic [AW-1:0]             mem_raddr;

  logic                      cmd_fire;
  logic                      out_free;
  logic                      res_load;
  logic                      full;
  logic                      empty;
  logic [CMPW-1:0]           cnt_x;
  logic [CMPW-1:0]           pos_x;
  logic                      ins_bad;
  logic                      del_bad;
  logic [AW-1:0]             ins_idx;
  logic [AW-1:0]             del_idx;
  logic                      dump_last;

  assign cmd_i.ready = (state_q == S_IDLE);
  assign cmd_fire    = cmd_i.valid && cmd_i.ready;
  assign out_free    = !res_valid_q || res_o.ready;
  assign res_load    = out_free && ((state_q == S_RESP) || (state_q == S_DUMP_WR));

  assign full    = (cnt_q == CW'(CAPACITY));
  assign empty   = (cnt_q == '0);
  assign cnt_x   = CMPW'(cnt_q);
  assign pos_x   = CMPW'(cmd_i.position);
  assign ins_bad = (pos_x == '0) || (pos_x > cnt_x + CMPW'(1));
  assign del_bad = (pos_x == '0) || (pos_x > cnt_x);

  always_comb begin
    unique case (cmd_e'(cmd_i.command))
      CMD_INS_FIRST: ins_idx = '0;
      CMD_INS_LAST:  ins_idx = AW'(cnt_q);
      default:       ins_idx = AW'(cmd_i.position - POS_W'(1));
    endcase
    unique case (cmd_e'(cmd_i.command))
      CMD_DEL_FIRST: del_idx = '0;
      CMD_DEL_LAST:  del_idx = AW'(cnt_q - CW'(1));
      default:       del_idx = AW'(cmd_i.position - POS_W'(1));
    endcase
  end

  assign dump_last = (CW'(ptr_q) + CW'(1) == cnt_q);

  // memory port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = dst_q;
    mem_wdata = rd_data_q;
    mem_re    = 1'b0;
    mem_raddr = ptr_q;
    unique case (state_q)
      S_SHIFT: begin
        if (mv_q) begin
          mem_we = 1'b1;
        end else if (rem_q == '0 && up_q) begin
          mem_we    = 1'b1;
          mem_waddr = idx_q;
          mem_wdata = val_q;
        end
        mem_re = (rem_q != '0);
      end
      S_DUMP_RD: mem_re = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      entries_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_q <= entries_q[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cnt_q        <= '0;
      idx_q        <= '0;
      ptr_q        <= '0;
      dst_q        <= '0;
      rem_q        <= '0;
      mv_q         <= 1'b0;
      up_q         <= 1'b0;
      val_q        <= '0;
      st_q         <= ST_OK;
      res_valid_q  <= 1'b0;
      res_value_q  <= '0;
      res_status_q <= ST_OK;
      res_count_q  <= '0;
      res_last_q   <= 1'b0;
    end else begin
      if (res_load) begin
        res_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (cmd_fire) begin
            val_q <= cmd_i.value;
            mv_q  <= 1'b0;
            unique case (cmd_e'(cmd_i.command))
              CMD_INS_FIRST, CMD_INS_LAST, CMD_INS_AT: begin
                if (cmd_e'(cmd_i.command) == CMD_INS_AT && ins_bad) begin
                  st_q    <= ST_BADPOS;
                  state_q <= S_RESP;
                end else if (full) begin
                  st_q    <= ST_FULL;
                  state_q <= S_RESP;
                end else begin
                  idx_q   <= ins_idx;
                  rem_q   <= cnt_q - CW'(ins_idx);
                  ptr_q   <= AW'(cnt_q - CW'(1));
                  up_q    <= 1'b1;
                  state_q <= S_SHIFT;
                end
              end
              CMD_DEL_FIRST, CMD_DEL_LAST, CMD_DEL_AT: begin
                if (cmd_e'(cmd_i.command) == CMD_DEL_AT && del_bad) begin
                  st_q    <= ST_BADPOS;
                  state_q <= S_RESP;
                end else if (empty) begin
                  st_q    <= ST_EMPTY;
                  state_q <= S_RESP;
                end else begin
                  idx_q   <= del_idx;
                  rem_q   <= cnt_q - CW'(1) - CW'(del_idx);
                  ptr_q   <= del_idx + AW'(1);
                  up_q    <= 1'b0;
                  state_q <= S_SHIFT;
                end
              end
              CMD_DUMP: begin
                if (empty) begin
                  st_q    <= ST_EMPTY;
                  state_q <= S_RESP;
                end else begin
                  ptr_q   <= '0;
                  state_q <= S_DUMP_RD;
                end
              end
              default: ;
            endcase
          end
        end
        S_SHIFT: begin
          if (rem_q != '0) begin
            mv_q  <= 1'b1;
            dst_q <= up_q ? ptr_q + AW'(1) : ptr_q - AW'(1);
            ptr_q <= up_q ? ptr_q - AW'(1) : ptr_q + AW'(1);
            rem_q <= rem_q - CW'(1);
          end else begin
            mv_q <= 1'b0;
            if (!mv_q) begin
              cnt_q   <= up_q ? cnt_q + CW'(1) : cnt_q - CW'(1);
              st_q    <= ST_OK;
              state_q <= S_RESP;
            end
          end
        end
        S_RESP: begin
          if (out_free) begin
            res_value_q  <= '0;
            res_status_q <= st_q;
            res_count_q  <= CNT_W'(cnt_q);
            res_last_q   <= 1'b1;
            state_q      <= S_IDLE;
          end
        end
        S_DUMP_RD: state_q <= S_DUMP_WR;
        S_DUMP_WR: begin
          if (out_free) begin
            res_value_q  <= rd_data_q;
            res_status_q <= ST_OK;
            res_count_q  <= CNT_W'(cnt_q);
            res_last_q   <= dump_last;
            if (dump_last) begin
              state_q <= S_IDLE;
            end else begin
              ptr_q   <= ptr_q + AW'(1);
              state_q <= S_DUMP_RD;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign res_o.valid       = res_valid_q;
  assign res_o.entry_value = res_value_q;
  assign res_o.status      = res_status_q;
  assign res_o.entry_count = res_count_q;
  assign res_o.last        = res_last_q;

endmodule

/* rtl/pidl_checker.sv */
// port-level checks on the list result channel, bound to the top level
`include "assert_macros.svh"

module pidl_checker import pidl_pkg::*; #(
  parameter int unsigned CAPACITY = 32
) (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      res_valid_i,
  input logic                      res_ready_i,
  input logic signed [VALUE_W-1:0] res_entry_value_i,
  input logic [STATUS_W-1:0]       res_status_i,
  input logic [CNT_W-1:0]          res_entry_count_i,
  input logic                      res_last_i
);

  localparam int unsigned CMPW = CNT_W + 1;

  // a stalled result beat holds
  `PIDL_ASSERT_NEXT(a_res_hold, res_valid_i && !res_ready_i, res_valid_i && $stable(res_entry_value_i))

  // the count never goes beyond the capacity
  `PIDL_ASSERT(a_count_range, res_valid_i |-> (CMPW'(res_entry_count_i) <= CMPW'(CAPACITY)))

  // an error beat is a single final beat with no value
  `PIDL_ASSERT(a_err_single, res_valid_i && (res_status_i != ST_OK) |-> res_last_i && (res_entry_value_i == '0))

  // beats before the last one come only from a dump of a non-empty list
  `PIDL_ASSERT(a_dump_body, res_valid_i && !res_last_i |-> (res_status_i == ST_OK) && (res_entry_count_i != '0))

endmodule

bind positional_insert_delete_list_top pidl_checker #(
  .CAPACITY (CAPACITY)
) u_pidl_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .res_valid_i       (res_o.valid),
  .res_ready_i       (res_o.ready),
  .res_entry_value_i (res_o.entry_value),
  .res_status_i      (res_o.status),
  .res_entry_count_i (res_o.entry_count),
  .res_last_i        (res_o.last)
);

/* tb/testbench.sv */
// self-checking testbench for the positional insert/delete list: directed table then random traffic
module testbench;
  import pidl_pkg::*;

  localparam int unsigned CAPACITY     = 32;
  localparam int          RANDOM_ITEMS = 450;
  localparam int          PHASE_ITEMS  = 120;
  localparam int          HOLD_AFTER   = 150;
  localparam int          HOLD_CYCLES  = 300;
  localparam int          TAIL_CYCLES  = 80;
  localparam int          CYCLE_LIMIT  = 1_500_000;
  localparam int          N_DIRECTED   = 23;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;

  typedef struct packed {
    logic signed [VALUE_W-1:0] entry_value;
    status_e                   status;
    logic [CNT_W-1:0]          entry_count;
    logic                      last;
  } result_t;

  typedef struct packed {
    logic [CMD_W-1:0]          command;
    logic signed [VALUE_W-1:0] value;
    logic [POS_W-1:0]          position;
    logic                      typed;
    status_e                   want_status;
    logic [CNT_W-1:0]          want_count;
  } stim_t;

  // command, value, position, typed, status, count
  stim_t directed_table [N_DIRECTED] = '{
    '{CMD_DUMP,      32'sd0,            6'd0,  1'b1, ST_EMPTY,  6'd0},
    '{CMD_DEL_FIRST, 32'sd0,            6'd0,  1'b1, ST_EMPTY,  6'd0},
    '{CMD_DEL_LAST,  32'sd0,            6'd0,  1'b1, ST_EMPTY,  6'd0},
    '{CMD_DEL_AT,    32'sd0,            6'd1,  1'b1, ST_BADPOS, 6'd0},
    '{CMD_DEL_AT,    32'sd0,            6'd0,  1'b1, ST_BADPOS, 6'd0},
    '{CMD_INS_AT,    32'sd5,            6'd0,  1'b1, ST_BADPOS, 6'd0},
    '{CMD_INS_AT,    32'sd5,            6'd2,  1'b1, ST_BADPOS, 6'd0},
    '{CMD_INS_AT,    32'sh8000_0000,    6'd1,  1'b1, ST_OK,     6'd1},
    '{CMD_INS_FIRST, 32'sh7fff_ffff,    6'd0,  1'b1, ST_OK,     6'd2},
    '{CMD_INS_LAST,  -32'sd1,           6'd63, 1'b1, ST_OK,     6'd3},
    '{CMD_INS_AT,    32'sd9,            6'd63, 1'b1, ST_BADPOS, 6'd3},
    '{CMD_INS_AT,    32'sd0,            6'd4,  1'b1, ST_OK,     6'd4},
    '{CMD_INS_AT,    32'sh5555_5555,    6'd2,  1'b1, ST_OK,     6'd5},
    '{CMD_DEL_AT,    32'sd0,            6'd6,  1'b1, ST_BADPOS, 6'd5},
    '{CMD_DEL_AT,    32'sd0,            6'd63, 1'b1, ST_BADPOS, 6'd5},
    '{CMD_DUMP,      32'sd0,            6'd0,  1'b0, ST_OK,     6'd0},
    '{CMD_DEL_AT,    32'sd0,            6'd3,  1'b1, ST_OK,     6'd4},
    '{CMD_DEL_FIRST, 32'sd0,            6'd0,  1'b1, ST_OK,     6'd3},
    '{CMD_DEL_LAST,  32'sd0,            6'd0,  1'b1, ST_OK,     6'd2},
    '{CMD_UNUSED,    32'sh1234_5678,    6'd63, 1'b0, ST_OK,     6'd0},
    '{CMD_DUMP,      32'sd0,            6'd0,  1'b0, ST_OK,     6'd0},
    '{CMD_INS_AT,    32'shaaaa_aaaa,    6'd3,  1'b1, ST_OK,     6'd3},
    '{CMD_DUMP,      32'sd0,            6'd0,  1'b0, ST_OK,     6'd0}
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  pidl_cmd_if cmd_if ();
  pidl_res_if res_if ();

  positional_insert_delete_list_top #(
    .CAPACITY(CAPACITY)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cmd_if),
    .res_o (res_if)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  logic signed [VALUE_W-1:0] list_cells [CAPACITY];
  int                        list_len = 0;
  result_t                   expected_results [$];
  stim_t                     offered_items [$];
  int                        errors = 0;
  int                        cycles = 0;
  int                        results_taken = 0;
  int                        send_burst = 0;
  int                        recv_burst = 0;

  function automatic int draw_wait(inout int burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 29) == 0) begin
      burst = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 18);
  endfunction

  // applies one command to the list copy and, when emit is set, queues the results it gives
  function automatic void list_apply(stim_t it, bit emit);
    status_e st;
    int      idx;
    int      i;
    st = ST_OK;
    case (it.command)
      CMD_INS_FIRST, CMD_INS_LAST, CMD_INS_AT: begin
        if (it.command == CMD_INS_AT && (it.position < 1 || it.position > list_len + 1)) begin
          st = ST_BADPOS;
        end else if (list_len >= CAPACITY) begin
          st = ST_FULL;
        end else begin
          if (it.command == CMD_INS_FIRST) idx = 0;
          else if (it.command == CMD_INS_LAST) idx = list_len;
          else idx = it.position - 1;
          for (i = list_len; i > idx; i--) list_cells[i] = list_cells[i-1];
          list_cells[idx] = it.value;
          list_len++;
        end
      end
      CMD_DEL_FIRST, CMD_DEL_LAST, CMD_DEL_AT: begin
        if (it.command == CMD_DEL_AT) begin
          if (it.position < 1 || it.position > list_len) st = ST_BADPOS;
        end else if (list_len == 0) begin
          st = ST_EMPTY;
        end
        if (st == ST_OK) begin
          if (it.command == CMD_DEL_FIRST) idx = 0;
          else if (it.command == CMD_DEL_LAST) idx = list_len - 1;
          else idx = it.position - 1;
          for (i = idx; i + 1 < list_len; i++) list_cells[i] = list_cells[i+1];
          list_len--;
        end
      end
      CMD_DUMP: begin
        if (!emit) return;
        if (list_len == 0) begin
          expected_results.push_back('{'0, ST_EMPTY, '0, 1'b1});
        end else begin
          for (i = 0; i < list_len; i++) begin
            expected_results.push_back('{list_cells[i], ST_OK, CNT_W'(list_len),
                                         i + 1 == list_len});
          end
        end
        return;
      end
      default: return;
    endcase
    if (emit) expected_results.push_back('{'0, st, CNT_W'(list_len), 1'b1});
  endfunction

  function automatic stim_t random_item(bit filling);
    stim_t it;
    int    pick;
    int    limit;
    it = '0;
    it.want_status = ST_OK;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      it.command = CMD_DUMP;
    end else if (pick < 10) begin
      it.command = CMD_UNUSED;
    end else if (pick < (filling ? 75 : 35)) begin
      case ($urandom_range(0, 2))
        0:       it.command = CMD_INS_FIRST;
        1:       it.command = CMD_INS_LAST;
        default: it.command = CMD_INS_AT;
      endcase
    end else begin
      case ($urandom_range(0, 2))
        0:       it.command = CMD_DEL_FIRST;
        1:       it.command = CMD_DEL_LAST;
        default: it.command = CMD_DEL_AT;
      endcase
    end
    case ($urandom_range(0, 39))
      0:       it.value = 32'sh8000_0000;
      1:       it.value = 32'sh7fff_ffff;
      2:       it.value = '0;
      3:       it.value = '1;
      default: it.value = $urandom;
    endcase
    limit = (it.command == CMD_INS_AT) ? list_len + 1 : list_len;
    pick = $urandom_range(0, 19);
    if (pick < 15 && limit > 0) it.position = POS_W'($urandom_range(1, limit));
    else if (pick == 15) it.position = '0;
    else if (pick == 16) it.position = POS_W'(limit + 1);
    else it.position = POS_W'($urandom_range(0, 63));
    return it;
  endfunction

  task automatic check_field(string name, logic [VALUE_W-1:0] want, logic [VALUE_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected 'h%0h, got 'h%0h", name, want, got);
      errors++;
    end
  endtask

  task automatic send_item(stim_t it);
    int gap;
    gap = draw_wait(send_burst);
    if (gap > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    offered_items.push_back(it);
    cmd_if.valid    <= 1'b1;
    cmd_if.command  <= it.command;
    cmd_if.value    <= it.value;
    cmd_if.position <= it.position;
    @(posedge clk_i);
    while (!cmd_if.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // result beats checked before the command beat of the same edge is predicted
  always @(posedge clk_i) begin
    result_t want;
    stim_t   item;
    if (res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
      if (expected_results.size() == 0) begin
        $error("result beat with nothing expected: value 'h%0h status %0d count %0d",
               res_if.entry_value, res_if.status, res_if.entry_count);
        errors++;
      end else begin
        want = expected_results.pop_front();
        check_field("entry_value", want.entry_value, res_if.entry_value);
        check_field("status", VALUE_W'(want.status), VALUE_W'(res_if.status));
        check_field("entry_count", VALUE_W'(want.entry_count), VALUE_W'(res_if.entry_count));
        check_field("last", VALUE_W'(want.last), VALUE_W'(res_if.last));
      end
    end
    if (cmd_if.valid === 1'b1 && cmd_if.ready === 1'b1) begin
      item = offered_items.pop_front();
      list_apply(item, !item.typed);
      if (item.typed) begin
        expected_results.push_back('{'0, item.want_status, item.want_count, 1'b1});
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  // sink side, with one long hold-off to back the block up
  initial begin
    int  stall;
    bit  held_off;
    held_off = 1'b0;
    res_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = draw_wait(recv_burst);
      if (!held_off && results_taken >= HOLD_AFTER) begin
        stall    = HOLD_CYCLES;
        held_off = 1'b1;
      end
      if (stall > 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      res_if.ready <= 1'b1;
      @(posedge clk_i);
      while (res_if.valid !== 1'b1) @(posedge clk_i);
      results_taken++;
      @(negedge clk_i);
    end
  end

  initial begin
    stim_t it;
    int    sent;
    rst_ni = 1'b0;
    cmd_if.valid    <= 1'b0;
    cmd_if.command  <= '0;
    cmd_if.value    <= '0;
    cmd_if.position <= '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int k = 0; k < N_DIRECTED; k++) send_item(directed_table[k]);

    // alternate growing and shrinking phases so the full and empty cases come up
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      it = random_item((sent / PHASE_ITEMS) % 2 == 0);
      send_item(it);
      if (it.command != CMD_UNUSED) sent++;
    end
    cmd_if.valid <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
